// File: rtl/assert_macros.svh
// assertion helpers, clocked on clk with rst_n low holding them off
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in a cycle implies the consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in a cycle implies the consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/jq_pkg.sv
// ----------------------------------------------------------------------------
// jq_pkg
// types, codes and defaults shared by the job queue modules
// ----------------------------------------------------------------------------
package jq_pkg;

    localparam int DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        FN_ENQUEUE = 3'd0,
        FN_DEQUEUE = 3'd1,
        FN_MODIFY  = 3'd2,
        FN_CHANGE  = 3'd3,
        FN_PROMOTE = 3'd4,
        FN_REORDER = 3'd5,
        FN_DISPLAY = 3'd6,
        FN_COUNT   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FS_NONE = 3'd0,
        FS_PRIO = 3'd1,
        FS_TYPE = 3'd2,
        FS_CPU  = 3'd3,
        FS_MEM  = 3'd4
    } fsel_t;

    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_PRIO = 2'd1,
        KEY_TYPE = 2'd2
    } key_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_FIND,
        S_SORT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [3:0]  jtype;
        logic [15:0] cpu;
        logic [15:0] mem;
    } job_t;

endpackage

// File: rtl/jq_mem.sv
// ----------------------------------------------------------------------------
// jq_mem
// job record store, one write port and one registered read port
// ----------------------------------------------------------------------------
module jq_mem #(
    parameter int DEPTH = jq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  jq_pkg::job_t       wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output jq_pkg::job_t       rd_data
);

    jq_pkg::job_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/job_queue_with_keyed_update.sv
// A bounded job queue of DEPTH records held in one synchronous RAM. Enqueue, count and
// the empty or full cases go straight to the result beat; dequeue first reads the head.
// Modify, change and promote scan the queue from the head through the RAM read port,
// one record a cycle. Reorder and display emit one record per pass over the whole
// queue (a selection pass on the key, ties broken by queue position), reading the
// records through the single RAM read port. A new command is taken once the previous
// one has placed its final result beat in the output register.
// ----------------------------------------------------------------------------
// job_queue_with_keyed_update
// fifo of job records with keyed update, sorted and plain listing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module job_queue_with_keyed_update #(
    parameter int DEPTH = jq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [15:0] job_id,
    input  logic [7:0]  priority_req,
    input  logic [3:0]  job_kind,
    input  logic [15:0] cpu_time,
    input  logic [15:0] memory_used,
    input  logic [2:0]  field_sel,
    input  logic [15:0] change_value,
    input  logic [7:0]  positions,
    input  logic [1:0]  sort_key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_job_id,
    output logic [7:0]  out_priority,
    output logic [3:0]  out_job_type,
    output logic [15:0] out_cpu_time,
    output logic [15:0] out_memory,
    output logic [1:0]  status,
    output logic [4:0]  entry_count,
    output logic        last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = 8 + AW;

    jq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  occ_reg, occ_next;
    logic [CW-1:0]  iss_reg, iss_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [CW-1:0]  rd_pos_reg, rd_pos_next;
    logic [AW-1:0]  rd_slot_reg, rd_slot_next;
    logic [CW-1:0]  emit_cnt_reg, emit_cnt_next;
    logic           have_last_reg, have_last_next;
    logic [KW-1:0]  last_key_reg, last_key_next;
    logic           best_vld_reg, best_vld_next;
    logic [KW-1:0]  best_key_reg, best_key_next;
    jq_pkg::job_t   best_rec_reg, best_rec_next;
    jq_pkg::job_t   res_rec_reg, res_rec_next;
    jq_pkg::status_t res_status_reg, res_status_next;
    logic           res_last_reg, res_last_next;
    logic           out_valid_reg, out_valid_next;
    jq_pkg::job_t   out_rec_reg, out_rec_next;
    jq_pkg::status_t out_status_reg, out_status_next;
    logic           out_last_reg, out_last_next;
    logic [4:0]     out_cnt_reg, out_cnt_next;

    jq_pkg::func_t  cmd_func_reg;
    jq_pkg::job_t   cmd_rec_reg;
    jq_pkg::fsel_t  cmd_fsel_reg;
    logic [15:0]    cmd_nval_reg;
    logic [7:0]     cmd_pos_reg;
    jq_pkg::key_t   cmd_key_reg;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    jq_pkg::job_t   wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    jq_pkg::job_t   rd_data;

    jq_pkg::job_t   in_rec;
    logic           in_take;
    logic           out_free;
    logic           found;
    logic           end_scan;
    logic [KW-1:0]  cand_key;
    logic           cand_take;
    logic [KW-1:0]  pick_key;
    jq_pkg::job_t   pick_rec;

    jq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ring slot of a queue position
    function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // smaller rank goes first
    function automatic logic [7:0] rank_of(jq_pkg::job_t r, jq_pkg::func_t f,
                                           jq_pkg::key_t k);
        logic [7:0] rk;
        rk = '0;
        if (f == jq_pkg::FN_REORDER)
        begin
            if (k == jq_pkg::KEY_PRIO)
            begin
                rk = ~r.prio;
            end
            else if (k == jq_pkg::KEY_TYPE)
            begin
                rk = {4'b0, r.jtype};
            end
        end
        return rk;
    endfunction

    function automatic jq_pkg::job_t apply_update(jq_pkg::job_t r, jq_pkg::func_t f,
                                                  jq_pkg::job_t c, jq_pkg::fsel_t fs,
                                                  logic [15:0] nv, logic [7:0] pos);
        jq_pkg::job_t u;
        logic [8:0]   sum;
        u   = r;
        sum = {1'b0, r.prio} + {1'b0, pos};
        if (f == jq_pkg::FN_MODIFY)
        begin
            u.prio  = c.prio;
            u.jtype = c.jtype;
            u.cpu   = c.cpu;
            u.mem   = c.mem;
        end
        else if (f == jq_pkg::FN_CHANGE)
        begin
            unique case (fs)
                jq_pkg::FS_PRIO: u.prio  = (nv > 16'd255) ? 8'hFF : nv[7:0];
                jq_pkg::FS_TYPE: u.jtype = (nv > 16'd15) ? 4'hF : nv[3:0];
                jq_pkg::FS_CPU:  u.cpu   = nv;
                jq_pkg::FS_MEM:  u.mem   = nv;
                default:         u       = r;
            endcase
        end
        else
        begin
            u.prio = sum[8] ? 8'hFF : sum[7:0];
        end
        return u;
    endfunction

    assign in_rec   = '{id: job_id, prio: priority_req, jtype: job_kind,
                        cpu: cpu_time, mem: memory_used};
    assign in_stall = (state_reg != jq_pkg::S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign found    = rd_vld_reg && (rd_data.id == cmd_rec_reg.id);
    assign end_scan = rd_vld_reg && (rd_pos_reg == occ_reg - CW'(1));
    assign cand_key = {rank_of(rd_data, cmd_func_reg, cmd_key_reg), rd_pos_reg[AW-1:0]};
    assign cand_take = rd_vld_reg && (!have_last_reg || cand_key > last_key_reg)
                       && (!best_vld_reg || cand_key < best_key_reg);
    assign pick_key = cand_take ? cand_key : best_key_reg;
    assign pick_rec = cand_take ? rd_data : best_rec_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        iss_next        = iss_reg;
        rd_vld_next     = 1'b0;
        rd_pos_next     = iss_reg;
        rd_slot_next    = slot_of(head_reg, iss_reg[AW-1:0]);
        emit_cnt_next   = emit_cnt_reg;
        have_last_next  = have_last_reg;
        last_key_next   = last_key_reg;
        best_vld_next   = best_vld_reg;
        best_key_next   = best_key_reg;
        best_rec_next   = best_rec_reg;
        res_rec_next    = res_rec_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_rec_next    = out_rec_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_cnt_next    = out_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(head_reg, occ_reg[AW-1:0]);
        wr_data         = in_rec;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        unique case (state_reg)
            jq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    res_rec_next    = '0;
                    res_last_next   = 1'b1;
                    res_status_next = jq_pkg::ST_EMPTY;
                    iss_next        = '0;
                    state_next      = jq_pkg::S_EMIT;
                    unique case (jq_pkg::func_t'(func))
                        jq_pkg::FN_ENQUEUE:
                        begin
                            if (occ_reg == CW'(DEPTH))
                            begin
                                res_status_next = jq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                occ_next        = occ_reg + CW'(1);
                                res_rec_next    = in_rec;
                                res_status_next = jq_pkg::ST_OK;
                            end
                        end
                        jq_pkg::FN_DEQUEUE:
                        begin
                            if (occ_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = jq_pkg::S_DEQ;
                            end
                        end
                        jq_pkg::FN_MODIFY, jq_pkg::FN_CHANGE, jq_pkg::FN_PROMOTE:
                        begin
                            res_status_next = jq_pkg::ST_NOTFOUND;
                            if (occ_reg != '0)
                            begin
                                state_next = jq_pkg::S_FIND;
                            end
                        end
                        jq_pkg::FN_REORDER, jq_pkg::FN_DISPLAY:
                        begin
                            if (occ_reg != '0)
                            begin
                                best_vld_next  = 1'b0;
                                have_last_next = 1'b0;
                                emit_cnt_next  = '0;
                                state_next     = jq_pkg::S_SORT;
                            end
                        end
                        default:
                        begin
                            res_status_next = jq_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            jq_pkg::S_DEQ:
            begin
                res_rec_next    = rd_data;
                res_status_next = jq_pkg::ST_OK;
                res_last_next   = 1'b1;
                head_next       = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                occ_next        = occ_reg - CW'(1);
                state_next      = jq_pkg::S_EMIT;
            end
            jq_pkg::S_FIND:
            begin
                if (found)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = rd_slot_reg;
                    wr_data         = apply_update(rd_data, cmd_func_reg, cmd_rec_reg,
                                                   cmd_fsel_reg, cmd_nval_reg, cmd_pos_reg);
                    res_rec_next    = wr_data;
                    res_status_next = jq_pkg::ST_OK;
                    state_next      = jq_pkg::S_EMIT;
                end
                else if (end_scan)
                begin
                    res_rec_next    = '0;
                    res_status_next = jq_pkg::ST_NOTFOUND;
                    state_next      = jq_pkg::S_EMIT;
                end
                else if (iss_reg < occ_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = slot_of(head_reg, iss_reg[AW-1:0]);
                    rd_vld_next = 1'b1;
                    iss_next    = iss_reg + CW'(1);
                end
            end
            jq_pkg::S_SORT:
            begin
                if (end_scan)
                begin
                    res_rec_next    = pick_rec;
                    res_status_next = jq_pkg::ST_OK;
                    res_last_next   = (emit_cnt_reg + CW'(1) == occ_reg);
                    last_key_next   = pick_key;
                    have_last_next  = 1'b1;
                    emit_cnt_next   = emit_cnt_reg + CW'(1);
                    state_next      = jq_pkg::S_EMIT;
                end
                else
                begin
                    if (cand_take)
                    begin
                        best_vld_next = 1'b1;
                        best_key_next = cand_key;
                        best_rec_next = rd_data;
                    end
                    if (iss_reg < occ_reg)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = slot_of(head_reg, iss_reg[AW-1:0]);
                        rd_vld_next = 1'b1;
                        iss_next    = iss_reg + CW'(1);
                    end
                end
            end
            jq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rec_next    = res_rec_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = res_last_reg;
                    // count travels with the beat so a stalled beat keeps it
                    out_cnt_next    = 5'(occ_reg);
                    iss_next        = '0;
                    best_vld_next   = 1'b0;
                    state_next      = res_last_reg ? jq_pkg::S_IDLE : jq_pkg::S_SORT;
                end
            end
            default:
            begin
                state_next = jq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jq_pkg::S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            emit_cnt_reg  <= '0;
            have_last_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            emit_cnt_reg  <= emit_cnt_next;
            have_last_reg <= have_last_next;
            best_vld_reg  <= best_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg     <= rd_pos_next;
        rd_slot_reg    <= rd_slot_next;
        last_key_reg   <= last_key_next;
        best_key_reg   <= best_key_next;
        best_rec_reg   <= best_rec_next;
        res_rec_reg    <= res_rec_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        out_rec_reg    <= out_rec_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_cnt_reg    <= out_cnt_next;
        if (in_take)
        begin
            cmd_func_reg <= jq_pkg::func_t'(func);
            cmd_rec_reg  <= in_rec;
            cmd_fsel_reg <= jq_pkg::fsel_t'(field_sel);
            cmd_nval_reg <= change_value;
            cmd_pos_reg  <= positions;
            cmd_key_reg  <= jq_pkg::key_t'(sort_key);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_job_id   = out_rec_reg.id;
    assign out_priority = out_rec_reg.prio;
    assign out_job_type = out_rec_reg.jtype;
    assign out_cpu_time = out_rec_reg.cpu;
    assign out_memory   = out_rec_reg.mem;
    assign status       = out_status_reg;
    assign entry_count  = out_cnt_reg;
    assign last         = out_last_reg;

    `ASSERT_ALWAYS(a_occ_bound, occ_reg <= CW'(DEPTH), "occupancy beyond depth")
    `ASSERT_IMPLIES(a_scan_pos, rd_vld_reg && (state_reg == jq_pkg::S_SORT),
        rd_pos_reg < occ_reg, "scan read beyond queue")
    `ASSERT_IMPLIES(a_emit_bound, state_reg == jq_pkg::S_SORT,
        emit_cnt_reg < occ_reg, "listing emitted more beats than records")
    `ASSERT_NEXT(a_occ_idle, (state_reg == jq_pkg::S_SORT) || (state_reg == jq_pkg::S_FIND),
        $stable(occ_reg) && $stable(head_reg), "queue moved during a scan")

endmodule
